>>> src/bwlr_pkg.sv
package bwlr_pkg;

    localparam int BYTE_W   = 8;
    localparam int BUDGET_W = 20;
    localparam int SUM_W    = 21;
    localparam int LEN_W    = 17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic commit;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic pos_full;
        logic sum_over;
        logic last_seen;
        logic out_busy;
    } stat_t;

endpackage

>>> src/bwlr_ctrl.sv
module bwlr_ctrl
    import bwlr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && aresetn) begin
                    if (!stat.pos_full) begin
                        state_next = ST_CHECK;
                    end else if (stat.in_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CHECK: begin
                if (stat.sum_over) begin
                    state_next = ST_POP;
                end else if (stat.last_seen) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = aresetn;
                cmd.accept = s_valid && aresetn;
            end
            ST_CHECK: begin
                // shrink while over budget, else record the window
                cmd.commit = !stat.sum_over;
            end
            ST_POP: begin
                cmd.pop = 1'b1;
            end
            ST_FINISH: begin
                // hold until the output register is free
                cmd.finish = !stat.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/bwlr_dp.sv
module bwlr_dp
    import bwlr_pkg::*;
#(
    parameter int MAX_LEN = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BUDGET_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0]   s_src_byte,
    input  logic [BYTE_W-1:0]   s_dst_byte,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LEN_W-1:0]    m_max_length,
    output logic                m_overflow,
    input  cmd_t                cmd,
    output stat_t               stat
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = AW + 1;

    logic [BYTE_W-1:0]   ring_mem [MAX_LEN];
    logic [BYTE_W-1:0]   rd_reg;

    logic [BUDGET_W-1:0] budget_reg;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       start_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CW-1:0]       best_reg;
    logic                ovf_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_ovf_reg;

    logic [BYTE_W-1:0]   cost;
    logic [CW-1:0]       win_len;
    logic                pos_full;
    logic                ring_we;

    assign cost     = (s_src_byte > s_dst_byte) ? (s_src_byte - s_dst_byte)
                                                : (s_dst_byte - s_src_byte);
    assign win_len  = pos_reg + CW'(1) - start_reg;
    assign pos_full = (pos_reg >= CW'(MAX_LEN));
    assign ring_we  = cmd.accept && !pos_full;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[pos_reg[AW-1:0]] <= cost;
        end
        rd_reg <= ring_mem[start_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= '0;
        end else if (cfg_we) begin
            budget_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.finish) begin
            pos_reg   <= '0;
            start_reg <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (pos_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_reg + SUM_W'(cost);
                end
            end
            if (cmd.pop) begin
                sum_reg   <= sum_reg - SUM_W'(rd_reg);
                start_reg <= start_reg + CW'(1);
            end
            if (cmd.commit) begin
                if (win_len > best_reg) begin
                    best_reg <= win_len;
                end
                pos_reg <= pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_len_reg <= LEN_W'(best_reg);
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_max_length = out_len_reg;
    assign m_overflow   = out_ovf_reg;

    assign stat.in_last   = s_last;
    assign stat.pos_full  = pos_full;
    assign stat.sum_over  = sum_reg > SUM_W'(budget_reg);
    assign stat.last_seen = last_reg;
    assign stat.out_busy  = out_valid_reg && !m_ready;

endmodule

>>> src/budget_window_longest_run_top.sv
// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// input    | s_valid s_ready s_src_byte s_dst_byte s_last  | in
// result   | m_valid m_ready m_max_length m_overflow       | out
// config   | cfg_valid cfg_ready cfg_data (budget)         | in
//
// An item is accepted, then its window is checked; each cost popped from the
// window adds a pop and another check. Pops are bounded by pushes, and the cost
// ring has a single read port; a new item is taken only once the last is done.
// An item past MAX_LEN is only accepted, and marks the run as overflowed.
// A last item then loads the result, waiting while an older result is stalled.
// Items keep flowing while a result waits; reset clears the run and budget.
module budget_window_longest_run_top
    import bwlr_pkg::*;
#(
    parameter int MAX_LEN = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUDGET_W-1:0] cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_src_byte,
    input  logic [BYTE_W-1:0]   s_dst_byte,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LEN_W-1:0]    m_max_length,
    output logic                m_overflow
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = aresetn;

    bwlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bwlr_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .s_src_byte   (s_src_byte),
        .s_dst_byte   (s_dst_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_max_length (m_max_length),
        .m_overflow   (m_overflow),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

>>> src/bwlr_checker.sv
module bwlr_checker
    import bwlr_pkg::*;
#(
    parameter int MAX_LEN = 65536
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [LEN_W-1:0] m_max_length,
    input logic             m_overflow
);

    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(MAX_LEN);
    localparam logic           MASKED    = (MAX_LEN >= (1 << LEN_W));

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_length) && $stable(m_overflow))
        else $error("result changed while stalled");

    // no item is taken while reset is applied
    a_no_accept_in_reset: assert property (@(posedge aclk)
        !aresetn |-> !(s_valid && s_ready))
        else $error("item accepted during reset");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> MASKED || ({1'b0, m_max_length} <= LEN_LIMIT))
        else $error("reported length above sequence limit");

endmodule

bind budget_window_longest_run_top bwlr_checker #(
    .MAX_LEN (MAX_LEN)
) u_bwlr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_max_length (m_max_length),
    .m_overflow   (m_overflow)
);
